### rtl/mfek_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfek_pkg: shared types and constants of the max flow unit
// Sizes of the residual matrix, field widths, sequencer states and the codes
// of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mfek_pkg;

  localparam int MAX_NODES = 64;
  localparam int CAP_BITS  = 16;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ID_W      = 7;
  localparam int CAP_IN_W  = 16;
  localparam int FLOW_W    = 22;
  localparam int RES_W     = CAP_BITS + 1;
  localparam int RES_AW    = 2 * NODE_W;
  localparam int RES_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ALU_W     = (FLOW_W > RES_W) ? FLOW_W : RES_W;

  localparam logic [RES_W-1:0]  RES_MAX  = '1;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;
  localparam logic [RES_W-1:0]  CAP_MASK = RES_W'((64'd1 << CAP_BITS) - 64'd1);

  localparam logic [ID_W-1:0] NUM_NODES_RST = 7'd64;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [1:0] {
    ALU_MIN,
    ALU_SUB,
    ALU_ADD_RES,
    ALU_ADD_FLOW
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_INIT,
    S_POP,
    S_LOAD_U,
    S_SCAN,
    S_NK_PAR,
    S_NK_RES,
    S_NK_MIN,
    S_UP_PAR,
    S_UP_RDF,
    S_UP_RDB,
    S_UP_WRB,
    S_ADD,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### rtl/mfek_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfek_ram: simple dual port ram
// One write port and one read port, read data registered, no reset.
// ----------------------------------------------------------------------------
module mfek_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/mfek_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfek_alu: shared add / subtract unit
// One adder serves the bottleneck minimum, the forward residual update, the
// saturating reverse residual update and the saturating flow total.
// ----------------------------------------------------------------------------
module mfek_alu (
  input  mfek_pkg::alu_req_t           req_i,
  output logic [mfek_pkg::ALU_W-1:0]   res_o
);
  import mfek_pkg::*;

  logic             sub;
  logic [ALU_W:0]   b_x;
  logic [ALU_W:0]   sum;
  logic             borrow;

  always_comb begin
    sub    = (req_i.op == ALU_MIN) || (req_i.op == ALU_SUB);
    b_x    = sub ? {1'b0, ~req_i.b} : {1'b0, req_i.b};
    sum    = {1'b0, req_i.a} + b_x + (ALU_W + 1)'(sub);
    // no carry out of a - b means a < b
    borrow = sub & ~sum[ALU_W];
    case (req_i.op)
      ALU_MIN:      res_o = borrow ? req_i.a : req_i.b;
      ALU_SUB:      res_o = sum[ALU_W-1:0];
      ALU_ADD_RES:  res_o = (sum > (ALU_W + 1)'(RES_MAX)) ? ALU_W'(RES_MAX)
                                                          : sum[ALU_W-1:0];
      ALU_ADD_FLOW: res_o = (sum > (ALU_W + 1)'(FLOW_MAX)) ? ALU_W'(FLOW_MAX)
                                                           : sum[ALU_W-1:0];
      default:      res_o = sum[ALU_W-1:0];
    endcase
  end

endmodule
`default_nettype wire

### rtl/max_flow_edmonds_karp_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_unit: maximum flow by breadth-first augmenting paths
// A sequencer walks a residual capacity matrix held in one ram, with one
// shared adder for bottleneck, residual and total updates.
// ----------------------------------------------------------------------------
// load item: accepted back to back, no result
// compute item: per search S_INIT, then S_POP, S_LOAD_U, S_SCAN per dequeued
//   node (scan stops at the sink); per path S_NK_PAR/RES/MIN a hop for the
//   bottleneck, S_UP_PAR/RDF/RDB/WRB a hop for the update, S_ADD for the total
// reset: a clearing pass zeroes all MAX_NODES * MAX_NODES (4096) entries,
//   in_ready_o stays low meanwhile; config writes are taken at once
module max_flow_edmonds_karp_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mfek_pkg::ID_W-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            req_type_i,
  input  wire logic [mfek_pkg::ID_W-1:0]       arc_tail_i,
  input  wire logic [mfek_pkg::ID_W-1:0]       arc_head_i,
  input  wire logic [mfek_pkg::CAP_IN_W-1:0]   arc_capacity_i,
  input  wire logic [mfek_pkg::ID_W-1:0]       source_node_i,
  input  wire logic [mfek_pkg::ID_W-1:0]       sink_node_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [mfek_pkg::FLOW_W-1:0]          max_flow_value_o
);
  import mfek_pkg::*;

  state_e               state_q, state_d;
  logic [RES_AW-1:0]    clr_q, clr_d;
  logic [ID_W-1:0]      num_nodes_q;
  logic [CNT_W-1:0]     n_eff;

  logic [NODE_W-1:0]    s_q, s_d, t_q, t_d, u_q, u_d;
  logic [NODE_W-1:0]    tr_v_q, tr_v_d, tr_p_q, tr_p_d;
  logic [CNT_W-1:0]     v_iss_q, v_iss_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [NODE_W-1:0]    chk_v_q, chk_v_d;
  logic                 chk_last_q, chk_last_d;
  logic [CNT_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic [RES_W-1:0]     neck_q, neck_d;
  logic [FLOW_W-1:0]    total_q, total_d;
  logic                 out_valid_q, out_valid_d;
  logic [FLOW_W-1:0]    out_value_q, out_value_d;

  logic                 res_we;
  logic [RES_AW-1:0]    res_waddr, res_raddr;
  logic [RES_W-1:0]     res_wdata, res_rdata;
  logic                 par_we;
  logic [NODE_W-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;
  logic                 q_we;
  logic [NODE_W-1:0]    q_waddr, q_wdata, q_raddr, q_rdata;

  alu_req_t             alu_req;
  logic [ALU_W-1:0]     alu_res;

  logic                 load_ok, comp_ok, issue, hit, leave;

  mfek_ram #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  mfek_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  mfek_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  mfek_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // node count clamped to 1..MAX_NODES
  always_comb begin
    if (num_nodes_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_nodes_q) > MAX_NODES) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(num_nodes_q);
    end
  end

  always_comb begin
    load_ok = (arc_tail_i != '0) && (int'(arc_tail_i) <= MAX_NODES) &&
              (arc_head_i != '0) && (int'(arc_head_i) <= MAX_NODES);
    comp_ok = (source_node_i != '0) && (int'(source_node_i) <= int'(n_eff)) &&
              (sink_node_i != '0) && (int'(sink_node_i) <= int'(n_eff)) &&
              (source_node_i != sink_node_i);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    s_d         = s_q;
    t_d         = t_q;
    u_d         = u_q;
    tr_v_d      = tr_v_q;
    tr_p_d      = tr_p_q;
    v_iss_d     = v_iss_q;
    chk_vld_d   = 1'b0;
    chk_v_d     = chk_v_q;
    chk_last_d  = chk_last_q;
    head_d      = head_q;
    tail_d      = tail_q;
    visited_d   = visited_q;
    neck_d      = neck_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    in_ready_o  = 1'b0;

    res_we      = 1'b0;
    res_waddr   = clr_q;
    res_wdata   = '0;
    res_raddr   = {u_q, v_iss_q[NODE_W-1:0]};
    par_we      = 1'b0;
    par_waddr   = chk_v_q;
    par_wdata   = u_q;
    par_raddr   = tr_v_q;
    q_we        = 1'b0;
    q_waddr     = tail_q[NODE_W-1:0];
    q_wdata     = chk_v_q;
    q_raddr     = head_q[NODE_W-1:0];

    alu_req.op  = ALU_MIN;
    alu_req.a   = ALU_W'(neck_q);
    alu_req.b   = ALU_W'(res_rdata);

    issue       = 1'b0;
    leave       = 1'b0;
    hit         = chk_vld_q && !visited_q[chk_v_q] && (res_rdata != '0);

    case (state_q)
      S_CLR: begin
        res_we    = 1'b1;
        res_waddr = clr_q;
        clr_d     = clr_q + RES_AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD) begin
            if (load_ok) begin
              res_we    = 1'b1;
              res_waddr = {NODE_W'(arc_tail_i - ID_W'(1)),
                           NODE_W'(arc_head_i - ID_W'(1))};
              res_wdata = RES_W'(arc_capacity_i) & CAP_MASK;
            end
          end else begin
            s_d     = NODE_W'(source_node_i - ID_W'(1));
            t_d     = NODE_W'(sink_node_i - ID_W'(1));
            total_d = '0;
            state_d = comp_ok ? S_INIT : S_DONE;
          end
        end
      end
      S_INIT: begin
        visited_d      = '0;
        visited_d[s_q] = 1'b1;
        q_we           = 1'b1;
        q_waddr        = '0;
        q_wdata        = s_q;
        head_d         = '0;
        tail_d         = CNT_W'(1);
        state_d        = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_DONE;
        end else begin
          head_d  = head_q + CNT_W'(1);
          state_d = S_LOAD_U;
        end
      end
      S_LOAD_U: begin
        u_d     = q_rdata;
        v_iss_d = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // read of node v_iss_q overlaps the check of the node before it
        issue      = v_iss_q < n_eff;
        chk_v_d    = v_iss_q[NODE_W-1:0];
        chk_last_d = (v_iss_q == n_eff - CNT_W'(1));
        if (issue) begin
          v_iss_d = v_iss_q + CNT_W'(1);
        end
        if (hit) begin
          par_we = 1'b1;
          if (chk_v_q == t_q) begin
            leave   = 1'b1;
            tr_v_d  = t_q;
            neck_d  = RES_MAX;
            state_d = S_NK_PAR;
          end else begin
            visited_d[chk_v_q] = 1'b1;
            q_we               = 1'b1;
            tail_d             = tail_q + CNT_W'(1);
          end
        end
        if (chk_vld_q && chk_last_q && !leave) begin
          leave   = 1'b1;
          state_d = S_POP;
        end
        chk_vld_d = issue && !leave;
      end
      S_NK_PAR: begin
        state_d = S_NK_RES;
      end
      S_NK_RES: begin
        tr_p_d    = par_rdata;
        res_raddr = {par_rdata, tr_v_q};
        state_d   = S_NK_MIN;
      end
      S_NK_MIN: begin
        neck_d = RES_W'(alu_res);
        if (tr_p_q == s_q) begin
          tr_v_d  = t_q;
          state_d = S_UP_PAR;
        end else begin
          tr_v_d  = tr_p_q;
          state_d = S_NK_PAR;
        end
      end
      S_UP_PAR: begin
        state_d = S_UP_RDF;
      end
      S_UP_RDF: begin
        tr_p_d    = par_rdata;
        res_raddr = {par_rdata, tr_v_q};
        state_d   = S_UP_RDB;
      end
      S_UP_RDB: begin
        // forward residual drops while the reverse one is read
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(res_rdata);
        alu_req.b  = ALU_W'(neck_q);
        res_we     = 1'b1;
        res_waddr  = {tr_p_q, tr_v_q};
        res_wdata  = RES_W'(alu_res);
        res_raddr  = {tr_v_q, tr_p_q};
        state_d    = S_UP_WRB;
      end
      S_UP_WRB: begin
        alu_req.op = ALU_ADD_RES;
        alu_req.a  = ALU_W'(res_rdata);
        alu_req.b  = ALU_W'(neck_q);
        res_we     = 1'b1;
        res_waddr  = {tr_v_q, tr_p_q};
        res_wdata  = RES_W'(alu_res);
        tr_v_d     = tr_p_q;
        state_d    = (tr_p_q == s_q) ? S_ADD : S_UP_PAR;
      end
      S_ADD: begin
        alu_req.op = ALU_ADD_FLOW;
        alu_req.a  = ALU_W'(total_q);
        alu_req.b  = ALU_W'(neck_q);
        total_d    = FLOW_W'(alu_res);
        state_d    = S_INIT;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = total_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      num_nodes_q <= NUM_NODES_RST;
      chk_vld_q   <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      chk_vld_q   <= chk_vld_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_nodes_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    t_q         <= t_d;
    u_q         <= u_d;
    tr_v_q      <= tr_v_d;
    tr_p_q      <= tr_p_d;
    v_iss_q     <= v_iss_d;
    chk_v_q     <= chk_v_d;
    chk_last_q  <= chk_last_d;
    neck_q      <= neck_d;
    total_q     <= total_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o      = out_valid_q;
  assign max_flow_value_o = out_value_q;

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue read pointer passed write pointer");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> tail_q <= n_eff)
    else $error("more nodes queued than in use");

  a_source_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> visited_q[s_q])
    else $error("source not marked during search");

  a_neck_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UP_PAR |-> neck_q != '0)
    else $error("zero bottleneck on augmenting path");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");

endmodule
`default_nettype wire

### dv/max_flow_edmonds_karp_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_unit_tb: self-checking bench for the max flow unit
// Drives arc loads and flow queries through the valid/ready input, keeps its
// own residual matrix and breadth-first augmenting search to predict each
// total the script does not give, and compares each returned total in order.
// The node count register is changed between phases once the unit has drained.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp_unit_tb;
  import mfek_pkg::*;

  localparam int SCRIPT_N   = 24;
  localparam int RAND_ITEMS = 750;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     tail;
    logic [ID_W-1:0]     head;
    logic [CAP_IN_W-1:0] cap;
    logic [ID_W-1:0]     src;
    logic [ID_W-1:0]     dst;
  } flow_req_t;

  typedef struct packed {
    flow_req_t         req;
    logic              typed;
    logic [FLOW_W-1:0] flow;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ID_W-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                req_type_i;
  logic [ID_W-1:0]     arc_tail_i;
  logic [ID_W-1:0]     arc_head_i;
  logic [CAP_IN_W-1:0] arc_capacity_i;
  logic [ID_W-1:0]     source_node_i;
  logic [ID_W-1:0]     sink_node_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [FLOW_W-1:0]   max_flow_value_o;

  // predictor state
  logic [RES_W-1:0]  resid_q [MAX_NODES][MAX_NODES];
  logic [ID_W-1:0]   nodes_q;
  int                bfs_parent [MAX_NODES];
  logic [FLOW_W-1:0] flow_expect_q [$];

  script_row_t script [SCRIPT_N];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int loads_sent;
  int queries_sent;
  int results_checked;
  int nonzero_flows;
  int saturated_flows;
  int cfg_writes;

  max_flow_edmonds_karp_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .arc_tail_i      (arc_tail_i),
    .arc_head_i      (arc_head_i),
    .arc_capacity_i  (arc_capacity_i),
    .source_node_i   (source_node_i),
    .sink_node_i     (sink_node_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_flow_value_o(max_flow_value_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic int node_span();
    int n;
    n = int'(nodes_q);
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  // breadth-first search, ascending scan, stops as soon as the sink is hit
  function automatic bit bfs_reaches(int s, int t, int n);
    bit seen [MAX_NODES];
    int fifo [MAX_NODES];
    int rd;
    int wr;
    int u;
    int v;
    foreach (seen[i]) seen[i] = 1'b0;
    rd = 0;
    wr = 1;
    fifo[0] = s;
    seen[s] = 1'b1;
    bfs_parent[s] = s;
    while (rd < wr) begin
      u = fifo[rd];
      rd++;
      for (v = 0; v < n; v++) begin
        if (!seen[v] && resid_q[u][v] != '0) begin
          bfs_parent[v] = u;
          if (v == t) return 1'b1;
          seen[v] = 1'b1;
          if (wr < MAX_NODES) begin
            fifo[wr] = v;
            wr++;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [FLOW_W-1:0] augment_total(int s, int t, int n);
    longint           total;
    longint           back;
    logic [RES_W-1:0] neck;
    int               u;
    int               v;
    total = 0;
    while (bfs_reaches(s, t, n)) begin
      neck = RES_MAX;
      for (v = t; v != s; v = u) begin
        u = bfs_parent[v];
        if (resid_q[u][v] < neck) neck = resid_q[u][v];
      end
      for (v = t; v != s; v = u) begin
        u = bfs_parent[v];
        back = longint'(resid_q[v][u]) + longint'(neck);
        resid_q[u][v] = resid_q[u][v] - neck;
        resid_q[v][u] = (back > longint'(RES_MAX)) ? RES_MAX : RES_W'(back);
      end
      total = total + longint'(neck);
      if (total > longint'(FLOW_MAX)) total = longint'(FLOW_MAX);
    end
    return FLOW_W'(total);
  endfunction

  // updates the predictor for one item, returns 1 when a total is due
  function automatic bit apply_request(input flow_req_t r, output logic [FLOW_W-1:0] flow);
    int n;
    int s;
    int t;
    flow = '0;
    if (r.kind == REQ_LOAD) begin
      if (r.tail >= 1 && r.tail <= MAX_NODES && r.head >= 1 && r.head <= MAX_NODES)
        resid_q[r.tail - 1][r.head - 1] = RES_W'(r.cap) & CAP_MASK;
      return 1'b0;
    end
    n = node_span();
    s = int'(r.src);
    t = int'(r.dst);
    if (s >= 1 && s <= n && t >= 1 && t <= n && s != t)
      flow = augment_total(s - 1, t - 1, n);
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // item construction
  // ------------------------------------------------------------------------
  function automatic flow_req_t load_req(int t, int h, int c);
    flow_req_t r;
    r.kind = REQ_LOAD;
    r.tail = ID_W'(t);
    r.head = ID_W'(h);
    r.cap  = CAP_IN_W'(c);
    r.src  = ID_W'($urandom);
    r.dst  = ID_W'($urandom);
    return r;
  endfunction

  function automatic flow_req_t flow_query(int s, int d);
    flow_req_t r;
    r.kind = REQ_COMPUTE;
    r.tail = ID_W'($urandom);
    r.head = ID_W'($urandom);
    r.cap  = CAP_IN_W'($urandom);
    r.src  = ID_W'(s);
    r.dst  = ID_W'(d);
    return r;
  endfunction

  function automatic script_row_t row(flow_req_t r, bit typed, int flow);
    script_row_t x;
    x.req   = r;
    x.typed = typed;
    x.flow  = FLOW_W'(flow);
    return x;
  endfunction

  // mostly nodes in use, some unused or invalid ones
  function automatic int pick_node(int n);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, n);
    if (sel < 88) return (n < MAX_NODES) ? $urandom_range(n + 1, MAX_NODES) : 0;
    return $urandom_range(0, 127);
  endfunction

  function automatic int pick_cap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 0;
    if (sel < 20) return 16'hFFFF;
    if (sel < 60) return $urandom_range(1, 20);
    return $urandom_range(0, 16'hFFFF);
  endfunction

  function automatic flow_req_t random_request(int n);
    if ($urandom_range(0, 99) < 35) return flow_query(pick_node(n), pick_node(n));
    return load_req(pick_node(n), pick_node(n), pick_cap());
  endfunction

  // ------------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------------
  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 31;
        recv_idle_pct = 84;
      end
      1: begin
        send_idle_pct = 84;
        recv_idle_pct = 31;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_request(flow_req_t r, bit typed, logic [FLOW_W-1:0] typed_flow);
    logic [FLOW_W-1:0] flow;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= r.kind;
    arc_tail_i     <= r.tail;
    arc_head_i     <= r.head;
    arc_capacity_i <= r.cap;
    source_node_i  <= r.src;
    sink_node_i    <= r.dst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (apply_request(r, flow)) begin
      flow_expect_q.push_back(typed ? typed_flow : flow);
      queries_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  // hold off until every total is back, then let a trailing load settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_node_count(int v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ID_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nodes_q = ID_W'(v);
    cfg_writes++;
  endtask

  // ------------------------------------------------------------------------
  // result side: check at the edge, then pick the next ready
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_side
    logic [FLOW_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flow_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("total %0d returned with no query outstanding",
                                   max_flow_value_o);
      end else begin
        want = flow_expect_q.pop_front();
        results_checked++;
        if (max_flow_value_o != 0) nonzero_flows++;
        if (max_flow_value_o == FLOW_MAX) saturated_flows++;
        if (max_flow_value_o != want) begin
          errors++;
          if (errors <= 10) $display("max_flow_value mismatch: expected %0d, got %0d",
                                     want, max_flow_value_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int phase;
    int len;
    int k;
    int pass_no;
    int sel;
    int count;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_LOAD;
    arc_tail_i     = '0;
    arc_head_i     = '0;
    arc_capacity_i = '0;
    source_node_i  = '0;
    sink_node_i    = '0;
    out_ready_i    = 1'b0;
    nodes_q        = NUM_NODES_RST;
    foreach (resid_q[i, j]) resid_q[i][j] = '0;
    errors          = 0;
    loads_sent      = 0;
    queries_sent    = 0;
    results_checked = 0;
    nonzero_flows   = 0;
    saturated_flows = 0;
    cfg_writes      = 0;
    set_idling(0);

    // directed, with the node count at its reset value
    script[0]  = row(flow_query(1, 2), 1'b1, 0);        // empty matrix
    script[1]  = row(flow_query(5, 5), 1'b1, 0);        // source is sink
    script[2]  = row(flow_query(0, 7), 1'b1, 0);        // node zero
    script[3]  = row(flow_query(3, 65), 1'b1, 0);       // sink past the count
    script[4]  = row(flow_query(127, 1), 1'b1, 0);
    script[5]  = row(load_req(0, 2, 100), 1'b0, 0);     // ignored loads
    script[6]  = row(load_req(2, 127, 100), 1'b0, 0);
    script[7]  = row(load_req(65, 1, 16'hFFFF), 1'b0, 0);
    script[8]  = row(load_req(1, 2, 7), 1'b0, 0);
    script[9]  = row(load_req(1, 2, 16'hFFFF), 1'b0, 0); // overwrite
    script[10] = row(load_req(2, 64, 16'hFFFF), 1'b0, 0);
    script[11] = row(load_req(1, 1, 16'h1234), 1'b0, 0); // self loop
    script[12] = row(flow_query(1, 64), 1'b1, 65535);
    script[13] = row(flow_query(64, 1), 1'b1, 65535);    // back along the reverse arcs
    script[14] = row(flow_query(2, 1), 1'b0, 0);
    script[15] = row(load_req(3, 4, 16'hFFFF), 1'b0, 0);
    script[16] = row(load_req(4, 3, 16'hFFFF), 1'b0, 0);
    script[17] = row(flow_query(3, 4), 1'b0, 0);
    script[18] = row(load_req(3, 4, 16'hFFFF), 1'b0, 0);
    script[19] = row(flow_query(3, 4), 1'b0, 0);         // reverse residual saturates
    script[20] = row(flow_query(4, 3), 1'b0, 0);         // bottleneck above 16 bits
    script[21] = row(load_req(63, 64, 0), 1'b0, 0);
    script[22] = row(load_req(64, 63, 16'h8001), 1'b0, 0);
    script[23] = row(flow_query(63, 64), 1'b0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < SCRIPT_N; k++)
      send_request(script[k].req, script[k].typed, script[k].flow);

    // random phases, each under its own node count
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      set_idling(sent * 3 / RAND_ITEMS);
      case (phase)
        0: count = 1;
        1: count = 127;
        2: count = 0;
        3: count = 64;
        default: begin
          sel = $urandom_range(0, 99);
          if (sel < 4) count = 0;
          else if (sel < 8) count = 127;
          else if (sel < 12) count = 1;
          else if (sel < 20) count = 64;
          else if (sel < 24) count = $urandom_range(65, 126);
          else count = $urandom_range(2, 12);
        end
      endcase
      set_node_count(count);
      len = $urandom_range(15, 50);
      for (k = 0; k < len; k++) begin
        send_request(random_request(node_span()), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    // wide fan of parallel paths, pushed twice so the reverse arcs grow past
    // 16 bits, then drained backwards to saturate the total
    set_idling(2);
    set_node_count(64);
    for (pass_no = 0; pass_no < 2; pass_no++) begin
      for (k = 2; k < MAX_NODES; k++) begin
        send_request(load_req(1, k, 16'hFFFF), 1'b0, '0);
        send_request(load_req(k, MAX_NODES, 16'hFFFF), 1'b0, '0);
      end
      send_request(load_req(1, MAX_NODES, 16'hFFFF), 1'b0, '0);
      send_request(flow_query(1, MAX_NODES), 1'b0, '0);
    end
    send_request(flow_query(MAX_NODES, 1), 1'b0, '0);

    drain();
    repeat (50) @(posedge clk_i);

    $display("covered %0d arc loads and %0d flow queries across %0d node count settings",
             loads_sent, queries_sent, cfg_writes);
    $display("%0d totals compared, %0d non-zero, %0d at the saturated limit, %0d errors",
             results_checked, nonzero_flows, saturated_flows, errors);
    if (errors == 0 && flow_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
